### hdl/wrm_pkg.sv
// Shared types and fixed widths of the windowed running moments block.
`timescale 1ns / 1ps
package wrm_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 54;
  localparam int MOM_W    = 64;
  localparam int CNT_W    = 32;
  localparam int ACC_W    = 128;
  localparam int MC_W     = 3;
  localparam int WL_W     = 9;
  localparam int DIVC_W   = 7;

  localparam logic CFG_MOMENT_COUNT  = 1'b0;
  localparam logic CFG_WINDOW_LENGTH = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POW, ST_CHECK, ST_START, ST_LOAD, ST_MUL_LO, ST_MUL_HI,
    ST_COMBINE, ST_ABS, ST_DIV, ST_STORE, ST_EMIT, ST_CLEAR
  } wrm_state_t;

  typedef struct packed {
    logic take;
    logic pow;
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic combine;
    logic absval;
    logic div;
    logic store;
    logic advance;
    logic clear;
  } wrm_cmd_t;

  typedef struct packed {
    logic pow_last;
    logic win_full;
    logic cnt_zero;
    logic order_last;
    logic div_last;
  } wrm_status_t;

endpackage

### hdl/wrm_ctrl.sv
// Controller state machine: sequences sample updates and per-order commits.
`timescale 1ns / 1ps
module wrm_ctrl
  import wrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_opcode,
  input  logic        out_ready,
  input  wrm_status_t status,
  output logic        in_ready,
  output logic        out_valid,
  output wrm_cmd_t    cmd
);

  wrm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = (in_opcode == OP_FLUSH) ? ST_START : ST_POW;
        end
      end
      ST_POW: begin
        cmd.pow = 1'b1;
        if (status.pow_last) state_next = ST_CHECK;
      end
      ST_CHECK: state_next = status.win_full ? ST_START : ST_IDLE;
      ST_START: state_next = status.cnt_zero ? ST_STORE : ST_LOAD;
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_COMBINE;
      end
      ST_COMBINE: begin
        cmd.combine = 1'b1;
        state_next  = ST_ABS;
      end
      ST_ABS: begin
        cmd.absval = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (status.div_last) state_next = ST_STORE;
      end
      ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.order_last) begin
            state_next = ST_CLEAR;
          end else begin
            cmd.advance = 1'b1;
            state_next  = ST_START;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hdl/wrm_dp.sv
// Datapath: power sums, moment store, multiplier steps and the shift-subtract divider.
`timescale 1ns / 1ps
module wrm_dp
  import wrm_pkg::*;
#(
  parameter int MAX_ORDERS    = 4,
  parameter int MAX_WINDOW    = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  wrm_cmd_t            cmd,
  input  logic                in_opcode,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [WL_W-1:0]     cfg_data,
  output wrm_status_t         status,
  output logic [MC_W-1:0]     out_order,
  output logic [MOM_W-1:0]    out_value,
  output logic [CNT_W-1:0]    out_seen,
  output logic                out_last
);

  localparam int IDX_W  = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int WC_W   = (FILL_W > WL_W) ? FILL_W : WL_W;
  localparam int AMAG_W = MOM_W + CNT_W;

  logic [SUM_W-1:0]    power_sums [MAX_ORDERS];
  logic [MOM_W-1:0]    moment_store [MAX_ORDERS];
  logic [FILL_W-1:0]   fill_position;
  logic [CNT_W-1:0]    record_count;
  logic [MC_W-1:0]     moment_count;
  logic [WL_W-1:0]     window_length;
  logic [IDX_W-1:0]    k;

  logic [SAMPLE_W-1:0] xmag;
  logic                xneg;
  logic [SUM_W-1:0]    p;
  logic [MOM_W-1:0]    omag;
  logic                oneg;
  logic [2*CNT_W-1:0]  plo, phi;
  logic [AMAG_W-1:0]   amag;
  logic [ACC_W-1:0]    acc;
  logic                neg;
  logic [ACC_W-1:0]    dvd;
  logic [CNT_W-1:0]    rem;
  logic [DIVC_W-1:0]   divc;

  logic [SUM_W+SAMPLE_W-1:0] pprod;
  logic [SUM_W-1:0]    p_next;
  logic [CNT_W-1:0]    wext, keep;
  logic [WC_W-1:0]     win_eff, wl_ext, fill_ext;
  logic [3:0]          cnt_eff;
  logic [ACC_W-1:0]    bterm, aterm;
  logic [CNT_W:0]      trial;
  logic                qbit;
  logic [MOM_W-1:0]    sat, val;
  logic [MOM_W-1:0]    min_mag;

  // Power step: multiply by the sample magnitude, then fix the sign mod 2^54.
  assign pprod  = p * (SUM_W+SAMPLE_W)'(xmag);
  assign p_next = xneg ? SUM_W'(0) - pprod[SUM_W-1:0] : pprod[SUM_W-1:0];

  assign wext = CNT_W'(fill_position);
  assign keep = (wext > record_count) ? '0 : record_count - wext;

  assign wl_ext   = WC_W'(window_length);
  assign fill_ext = WC_W'(fill_position);
  always_comb begin
    if (wl_ext == '0)                  win_eff = WC_W'(1);
    else if (wl_ext > WC_W'(MAX_WINDOW)) win_eff = WC_W'(MAX_WINDOW);
    else                               win_eff = wl_ext;
    if (moment_count == '0)                   cnt_eff = 4'd1;
    else if (4'(moment_count) > 4'(MAX_ORDERS)) cnt_eff = 4'(MAX_ORDERS);
    else                                      cnt_eff = 4'(moment_count);
  end

  assign bterm = ACC_W'($signed(power_sums[k])) << FRACTION_BITS;
  assign aterm = ACC_W'(amag);

  assign trial = {rem, dvd[ACC_W-1]};
  assign qbit  = (trial >= {1'b0, record_count});

  // Saturate the quotient to signed 64 bits.
  assign min_mag = {1'b1, {(MOM_W-1){1'b0}}};
  always_comb begin
    if (neg) begin
      if (dvd[ACC_W-1:MOM_W] != '0 || dvd[MOM_W-1:0] > min_mag) sat = min_mag;
      else sat = MOM_W'(0) - dvd[MOM_W-1:0];
    end else begin
      if (dvd[ACC_W-1:MOM_W] != '0 || dvd[MOM_W-1]) sat = {1'b0, {(MOM_W-1){1'b1}}};
      else sat = dvd[MOM_W-1:0];
    end
    val = status.cnt_zero ? moment_store[k] : sat;
  end

  assign status.pow_last   = (32'(k) == 32'(MAX_ORDERS - 1));
  assign status.win_full   = (fill_ext >= win_eff);
  assign status.cnt_zero   = (record_count == '0);
  assign status.order_last = ((4'(k) + 4'd1) == cnt_eff);
  assign status.div_last   = (divc == {DIVC_W{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ORDERS; i++) begin
        power_sums[i]   <= '0;
        moment_store[i] <= '0;
      end
      fill_position <= '0;
      record_count  <= '0;
      moment_count  <= MC_W'(4);
      window_length <= WL_W'(256);
      k             <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_MOMENT_COUNT) moment_count <= cfg_data[MC_W-1:0];
        else window_length <= cfg_data;
      end
      if (cmd.take) begin
        k <= '0;
        if (in_opcode == OP_SAMPLE) begin
          fill_position <= fill_position + FILL_W'(1);
          if (record_count != '1) record_count <= record_count + CNT_W'(1);
        end
      end
      if (cmd.pow) begin
        power_sums[k] <= power_sums[k] + p_next;
        k <= status.pow_last ? '0 : k + IDX_W'(1);
      end
      if (cmd.store && !status.cnt_zero) moment_store[k] <= sat;
      if (cmd.advance) k <= k + IDX_W'(1);
      if (cmd.clear) begin
        for (int i = 0; i < MAX_ORDERS; i++) power_sums[i] <= '0;
        fill_position <= '0;
        k             <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      xneg <= in_sample[SAMPLE_W-1];
      xmag <= in_sample[SAMPLE_W-1] ? SAMPLE_W'(0) - in_sample : in_sample;
      p    <= SUM_W'(1);
    end
    if (cmd.pow) p <= p_next;
    if (cmd.load) begin
      oneg <= moment_store[k][MOM_W-1];
      omag <= moment_store[k][MOM_W-1] ? MOM_W'(0) - moment_store[k] : moment_store[k];
    end
    if (cmd.mul_lo) plo <= omag[CNT_W-1:0] * keep;
    if (cmd.mul_hi) phi <= omag[MOM_W-1:CNT_W] * keep;
    if (cmd.combine) amag <= AMAG_W'(plo) + {phi, {CNT_W{1'b0}}};
    if (cmd.absval) acc <= oneg ? bterm - aterm : bterm + aterm;
    if (cmd.div) begin
      if (divc == '0) begin
        // First step takes the magnitude of the signed total.
        neg <= acc[ACC_W-1];
      end
    end
    if (cmd.store) begin
      out_order <= MC_W'(4'(k) + 4'd1);
      out_value <= val;
      out_seen  <= record_count;
      out_last  <= status.order_last;
    end
  end

  // Restoring divider, one quotient bit per cycle; the dividend shifts out as
  // quotient bits shift in.
  logic [ACC_W-1:0] acc_mag;
  assign acc_mag = acc[ACC_W-1] ? ACC_W'(0) - acc : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      divc <= '0;
    end else if (cmd.div) begin
      divc <= divc + DIVC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.combine) begin
      rem <= '0;
    end else if (cmd.div) begin
      if (divc == '0) begin
        if ({rem, acc_mag[ACC_W-1]} >= {1'b0, record_count})
          rem <= CNT_W'({rem, acc_mag[ACC_W-1]} - {1'b0, record_count});
        else rem <= CNT_W'({rem, acc_mag[ACC_W-1]});
        dvd <= {acc_mag[ACC_W-2:0],
                ({rem, acc_mag[ACC_W-1]} >= {1'b0, record_count})};
      end else begin
        rem <= qbit ? CNT_W'(trial - {1'b0, record_count}) : CNT_W'(trial);
        dvd <= {dvd[ACC_W-2:0], qbit};
      end
    end
  end

endmodule

### hdl/windowed_running_moments_core.sv
// Top level of the windowed running moments block.
// Input stream: s_tuser carries the opcode (0 sample, 1 flush), s_tdata[11:0]
// the signed sample. Output stream: one request per tracked order on commit,
// m_tuser the order, m_tdata the Q47.16 moment and the record count, m_tlast
// set on the highest tracked order. The cfg channel writes register 0 (moment
// count) or 1 (window length); cfg_ready is always high.
// A sample occupies the block while its power sums are updated one order per
// cycle through a single 54x12 multiplier. Each tracked order of a commit takes
// two 32x32 partial products, a combine and sign step, and a 128-step restoring
// divider producing one quotient bit per cycle, then the output wait. With no
// records yet the moments are emitted unchanged.
// One request is handled at a time. s_tready is low from acceptance until the
// power sums are updated or, on a commit, until the clear after the last
// result is taken. A stalled receiver simply holds the block in its output
// wait with m_tdata stable.
// Synchronous reset clears sums, moments, counts and restores moment count 4
// and window length 256.
`timescale 1ns / 1ps
module windowed_running_moments_core
  import wrm_pkg::*;
#(
  parameter int MAX_ORDERS    = 4,
  parameter int MAX_WINDOW    = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
  input  logic        s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [63:0] moment_value, [95:64] samples_seen
  output logic [2:0]  m_tuser,   // [2:0] moment_order
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  wrm_cmd_t    cmd;
  wrm_status_t status;
  logic [MOM_W-1:0] value;
  logic [CNT_W-1:0] seen;

  assign cfg_ready = 1'b1;

  wrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_opcode (s_tuser),
    .out_ready (m_tready),
    .status    (status),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .cmd       (cmd)
  );

  wrm_dp #(
    .MAX_ORDERS    (MAX_ORDERS),
    .MAX_WINDOW    (MAX_WINDOW),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_opcode (s_tuser),
    .in_sample (s_tdata[SAMPLE_W-1:0]),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_order (m_tuser),
    .out_value (value),
    .out_seen  (seen),
    .out_last  (m_tlast)
  );

  assign m_tdata = {seen, value};

endmodule

### hdl/wrm_chk.sv
// Port-level checks for the windowed running moments block, with their binding.
`timescale 1ns / 1ps
module wrm_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic        m_tlast,
  input logic [2:0]  m_tuser,
  input logic [95:0] m_tdata
);

  // The block never takes a request while a result is on offer.
  a_excl: assert property (@(posedge clk) !(s_tready && m_tvalid))
    else $error("input ready while output valid");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Sums are cleared in the cycle after the last result of a commit is taken.
  a_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid && !s_tready)
    else $error("no clear cycle after last result");

  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result offered right after reset");

endmodule

bind windowed_running_moments_core wrm_chk u_chk (.*);
